FILE: rtl/gpht_pkg.sv
// ----------------------------------------------------------------------------
// gpht_pkg
// Shared types and constants for the group-probed hash table.
// ----------------------------------------------------------------------------
package gpht_pkg;

    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_VALUE_BITS = 64;
    localparam int GROUP_SLOTS    = 16;
    localparam int LANE_BITS      = 4;
    localparam int KEY_BITS       = 64;
    localparam int CTRL_BITS      = 8;
    localparam int TAG_SHIFT      = 57;
    localparam logic [CTRL_BITS-1:0] CTRL_EMPTY = 8'h00;

    typedef logic [GROUP_SLOTS-1:0][CTRL_BITS-1:0] t_ctrl_row;
    typedef logic [GROUP_SLOTS-1:0][KEY_BITS-1:0]  t_key_row;

    typedef struct packed {
        logic [GROUP_SLOTS-1:0] lane_we;
        logic [CTRL_BITS-1:0]   ctrl;
        logic [KEY_BITS-1:0]    key;
    } t_bank_wr;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOFREE   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_VRD,
        S_VCAP,
        S_OUT
    } t_state;

endpackage

FILE: rtl/gpht_bank.sv
// ----------------------------------------------------------------------------
// gpht_bank
// Control bytes and keys, one memory per slot lane, read a whole group at once.
// ----------------------------------------------------------------------------
module gpht_bank
    import gpht_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int NGROUPS = CAPACITY / GROUP_SLOTS,
    localparam int GW      = $clog2(NGROUPS)
) (
    input  logic          i_clk,
    input  logic [GW-1:0] i_rd_grp,
    input  logic [GW-1:0] i_wr_grp,
    input  t_bank_wr      i_wr,
    output t_ctrl_row     o_ctrl_row,
    output t_key_row      o_key_row
);

    for (genvar l = 0; l < GROUP_SLOTS; l++) begin : g_lane
        logic [CTRL_BITS-1:0] ctrl_mem [NGROUPS];
        logic [KEY_BITS-1:0]  key_mem  [NGROUPS];

        always_ff @(posedge i_clk) begin
            if (i_wr.lane_we[l]) begin
                ctrl_mem[i_wr_grp] <= i_wr.ctrl;
                key_mem[i_wr_grp]  <= i_wr.key;
            end
            o_ctrl_row[l] <= ctrl_mem[i_rd_grp];
            o_key_row[l]  <= key_mem[i_rd_grp];
        end
    end

endmodule

FILE: rtl/group_probe_hash_table.sv
// ----------------------------------------------------------------------------
// group_probe_hash_table
// Open-addressed hash table in 16-slot groups with triangular group probing.
//
//   channel  | handshake          | words
//   request  | i_valid / o_stall  | i_req_type, i_key_hash, i_value_in
//   result   | o_valid / i_stall  | o_status, o_slot_index, o_key_out, o_value_out
//
// One request at a time. Each probed group passes through a group read of
// control and key lanes, then an evaluate step; a find hit adds a value read
// and capture, plus an accept step and a result handover for every request.
// After reset the control bytes are cleared, one group a cycle, with o_stall
// high. A stalled result holds the block.
// ----------------------------------------------------------------------------
module group_probe_hash_table
    import gpht_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [63:0] i_key_hash,
    input  logic [63:0] i_value_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot_index,
    output logic [63:0] o_key_out,
    output logic [63:0] o_value_out
);

    localparam int NGROUPS = CAPACITY / GROUP_SLOTS;
    localparam int GW      = $clog2(NGROUPS);
    localparam int SW      = GW + LANE_BITS;
    localparam int REMAIN0 = CAPACITY / 8 * 7;
    localparam int CW      = $clog2(REMAIN0 + 1);

    t_state                r_state, n_state;
    logic [GW-1:0]         r_clr, n_clr;
    logic [GW-1:0]         r_grp, n_grp;
    logic [GW-1:0]         r_k, n_k;
    logic                  r_type, n_type;
    logic [63:0]           r_hash, n_hash;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [LANE_BITS-1:0]  r_lane, n_lane;
    t_status               r_status, n_status;
    logic [63:0]           r_oval, n_oval;
    logic [CW-1:0]         r_remain, n_remain;

    t_ctrl_row             ctrl_row;
    t_key_row              key_row;
    t_bank_wr              bank_wr;
    logic [GW-1:0]         bank_wgrp;

    logic [VALUE_BITS-1:0] vmem [CAPACITY];
    logic [VALUE_BITS-1:0] r_vdata;
    logic                  v_we;
    logic [SW-1:0]         v_waddr;

    logic [GROUP_SLOTS-1:0] empty_m, hit_m;
    logic                   any_empty, any_hit;
    logic [LANE_BITS-1:0]   empty_lane, hit_lane;
    logic [CTRL_BITS-1:0]   tag;

    gpht_bank #(.CAPACITY(CAPACITY)) u_bank (
        .i_clk      (i_clk),
        .i_rd_grp   (r_grp),
        .i_wr_grp   (bank_wgrp),
        .i_wr       (bank_wr),
        .o_ctrl_row (ctrl_row),
        .o_key_row  (key_row)
    );

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            vmem[v_waddr] <= r_val;
        end
        r_vdata <= vmem[{r_grp, r_lane}];
    end

    assign tag = {1'b1, r_hash[63:TAG_SHIFT]};

    always_comb begin
        empty_m    = '0;
        hit_m      = '0;
        empty_lane = '0;
        hit_lane   = '0;
        for (int l = 0; l < GROUP_SLOTS; l++) begin
            empty_m[l] = (ctrl_row[l] == CTRL_EMPTY);
            hit_m[l]   = (ctrl_row[l] == tag) && (key_row[l] == r_hash);
        end
        for (int l = GROUP_SLOTS - 1; l >= 0; l--) begin
            if (empty_m[l]) begin
                empty_lane = LANE_BITS'(l);
            end
            if (hit_m[l]) begin
                hit_lane = LANE_BITS'(l);
            end
        end
        any_empty = |empty_m;
        any_hit   = |hit_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_remain <= CW'(REMAIN0);
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_remain <= n_remain;
            r_status <= n_status;
        end
        r_grp  <= n_grp;
        r_k    <= n_k;
        r_type <= n_type;
        r_hash <= n_hash;
        r_val  <= n_val;
        r_lane <= n_lane;
        r_oval <= n_oval;
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_grp     = r_grp;
        n_k       = r_k;
        n_type    = r_type;
        n_hash    = r_hash;
        n_val     = r_val;
        n_lane    = r_lane;
        n_status  = r_status;
        n_oval    = r_oval;
        n_remain  = r_remain;
        bank_wr   = '{lane_we: '0, ctrl: CTRL_EMPTY, key: r_hash};
        bank_wgrp = r_grp;
        v_we      = 1'b0;
        v_waddr   = {r_grp, empty_lane};
        o_stall   = (r_state != S_IDLE);
        o_valid   = (r_state == S_OUT);

        case (r_state)
            S_CLEAR: begin
                bank_wr.lane_we = '1;
                bank_wgrp       = r_clr;
                n_clr           = r_clr + 1'b1;
                if (r_clr == GW'(NGROUPS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_type = i_req_type;
                    n_hash = i_key_hash;
                    n_val  = i_value_in[VALUE_BITS-1:0];
                    n_grp  = i_key_hash[SW-1:LANE_BITS];
                    n_k    = GW'(1);
                    n_oval = '0;
                    if (!i_req_type && r_remain == '0) begin
                        n_status = ST_FULL;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!r_type && any_empty) begin
                    bank_wr.lane_we[empty_lane] = 1'b1;
                    bank_wr.ctrl                = tag;
                    v_we                        = 1'b1;
                    n_lane                      = empty_lane;
                    n_remain                    = r_remain - 1'b1;
                    n_oval                      = 64'(r_val);
                    n_status                    = ST_OK;
                    n_state                     = S_OUT;
                end else if (r_type && any_hit) begin
                    n_lane   = hit_lane;
                    n_status = ST_OK;
                    n_state  = S_VRD;
                end else if (r_k == GW'(NGROUPS - 1)) begin
                    n_status = r_type ? ST_NOTFOUND : ST_NOFREE;
                    n_oval   = '0;
                    n_state  = S_OUT;
                end else begin
                    n_grp   = r_grp + r_k;
                    n_k     = r_k + 1'b1;
                    n_state = S_READ;
                end
            end
            S_VRD: begin
                n_state = S_VCAP;
            end
            S_VCAP: begin
                n_oval  = 64'(r_vdata);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_status     = r_status;
    assign o_slot_index = (r_status == ST_OK) ? 8'({r_grp, r_lane}) : 8'd0;
    assign o_key_out    = (r_status == ST_OK) ? r_hash : 64'd0;
    assign o_value_out  = r_oval;

endmodule
